// ===== sv/cmbc_pkg.sv =====
package cmbc_pkg;

   // binary64 constants
   localparam logic [63:0] F64_ONE      = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] F64_HALF     = 64'h3FE0_0000_0000_0000;
   localparam logic [63:0] F64_TENT_K   = 64'h3FFF_D70A_3D70_A3D7;
   localparam logic [63:0] GROWTH_RESET = 64'h400F_2270_94D9_D1EC;
   localparam logic [63:0] SEED_RESET   = 64'h3FD0_0000_0000_0000;

   localparam int ROTATE_WIDTH = 8;

   // register indexes
   localparam logic [1:0] REG_GROWTH  = 2'd0;
   localparam logic [1:0] REG_SEED    = 2'd1;
   localparam logic [1:0] REG_DECRYPT = 2'd2;

   // floating point operation being run on the shared unit
   typedef enum logic [2:0] {
      OP_UX = 3'd0,  // u * x
      OP_1X = 3'd1,  // 1 - x
      OP_PQ = 3'd2,  // p * q
      OP_1T = 3'd3,  // 1 - t
      OP_CT = 3'd4   // 1.99 * (t or 1 - t)
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic   take_item;
      logic   load_out;
   } cmd_type;

   typedef struct packed {
      logic fpu_done;
      logic tent_lt;
      logic out_busy;
   } stat_type;

   function automatic logic [ROTATE_WIDTH-1:0] rot_left(
      input logic [ROTATE_WIDTH-1:0] v, input logic [2:0] d);
      logic [2*ROTATE_WIDTH-1:0] w;
      w = {v, v} << d;
      return w[2*ROTATE_WIDTH-1:ROTATE_WIDTH];
   endfunction

   function automatic logic [ROTATE_WIDTH-1:0] rot_right(
      input logic [ROTATE_WIDTH-1:0] v, input logic [2:0] d);
      logic [2*ROTATE_WIDTH-1:0] w;
      w = {v, v} >> d;
      return w[ROTATE_WIDTH-1:0];
   endfunction

endpackage

// ===== sv/chaotic_map_byte_cipher.sv =====
// Byte cipher driven by a logistic map and a tent map, both in binary64.
// req_ beats carry one byte and a restart flag (tuser); restart reloads
// both maps from the seed register before that byte is processed.
// rsp_ beats return exactly one transformed byte per request beat, in order.
// csr_ writes set growth rate (index 0), seed (index 1) and decrypt mode
// (index 2); csr_ready is always high, write only while the block is idle.
// One byte is worked at a time: three multiplies and one or two
// subtractions (the second only when the tent value is not below 0.5)
// run in turn on a single shared binary64 unit. A multiply sums four
// 27x27 partial products. The next byte can be taken in the cycle after
// the result register is loaded. A multiply with a NaN, infinity or zero
// operand, or a subtraction with a NaN or infinity operand, leaves the
// unit straight after its prepare step.
// When rsp_tready is low the block holds the finished byte in the result
// register; the next byte is worked meanwhile, and req_tready stays low
// until its result can be stored.
// Reset sets the registers to their defaults and both maps to the seed.
module chaotic_map_byte_cipher
   import cmbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   cmbc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   cmbc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .data_byte (req_tdata),
      .restart   (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata)
   );

   assign csr_ready = 1'b1;

endmodule

// ===== sv/cmbc_fpu.sv =====
module cmbc_fpu
   import cmbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_sub,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] result
);

   typedef enum logic [7:0] {
      F_IDLE = 8'b0000_0001,
      F_PREP = 8'b0000_0010,
      F_MUL  = 8'b0000_0100,
      F_ADD  = 8'b0000_1000,
      F_LZC  = 8'b0001_0000,
      F_SHL  = 8'b0010_0000,
      F_SHR  = 8'b0100_0000,
      F_RND  = 8'b1000_0000
   } fstate_type;

   localparam logic [63:0] DEF_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET   = 64'h0008_0000_0000_0000;

   fstate_type state_ff, state_in;
   logic [63:0] a_ff, b_ff;
   logic        sub_ff;
   logic [52:0] ma_ff, mb_ff;
   logic [55:0] big_ff, small_ff;
   logic        effsub_ff, sign_ff, zsign_ff, zero_ff;
   logic signed [13:0] ebase_ff, e_ff;
   logic [1:0]  cnt_ff;
   logic [105:0] w_ff, n_ff;
   logic [6:0]  lz_ff;
   logic [52:0] sig_ff;
   logic [10:0] ef_ff;
   logic        g_ff, s_ff, ovf_ff;
   logic        done_ff;
   logic [63:0] result_ff;

   // unpack
   logic [10:0] ea, eb, xa, xb;
   logic [51:0] fa, fb;
   logic [52:0] ma, mb;
   logic        sa, sb, sbx;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic        special;
   logic [63:0] spec_val;

   always_comb begin
      ea = a_ff[62:52];
      eb = b_ff[62:52];
      fa = a_ff[51:0];
      fb = b_ff[51:0];
      sa = a_ff[63];
      sb = b_ff[63];
      sbx = sb ^ sub_ff;
      ma = {ea != 11'd0, fa};
      mb = {eb != 11'd0, fb};
      xa = (ea == 11'd0) ? 11'd1 : ea;
      xb = (eb == 11'd0) ? 11'd1 : eb;
      a_nan = (ea == 11'h7FF) && (fa != 52'd0);
      b_nan = (eb == 11'h7FF) && (fb != 52'd0);
      a_inf = (ea == 11'h7FF) && (fa == 52'd0);
      b_inf = (eb == 11'h7FF) && (fb == 52'd0);
      a_zero = (ea == 11'd0) && (fa == 52'd0);
      b_zero = (eb == 11'd0) && (fb == 52'd0);
      special = 1'b1;
      spec_val = DEF_NAN;
      if (a_nan) begin
         spec_val = a_ff | QUIET;
      end else if (b_nan) begin
         spec_val = b_ff | QUIET;
      end else if (!sub_ff) begin
         if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            spec_val = DEF_NAN;
         end else if (a_inf || b_inf) begin
            spec_val = {sa ^ sb, 11'h7FF, 52'd0};
         end else if (a_zero || b_zero) begin
            spec_val = {sa ^ sb, 63'd0};
         end else begin
            special = 1'b0;
         end
      end else begin
         if (a_inf && b_inf && (sa != sbx)) begin
            spec_val = DEF_NAN;
         end else if (a_inf) begin
            spec_val = a_ff;
         end else if (b_inf) begin
            spec_val = {sbx, 11'h7FF, 52'd0};
         end else begin
            special = 1'b0;
         end
      end
   end

   // alignment for the add path
   logic        swap;
   logic [52:0] mbig, msmall;
   logic [10:0] xbig, xsmall, dexp;
   logic [5:0]  dc;
   logic [55:0] sext, sh, smask;
   logic        lost;

   always_comb begin
      swap   = {xa, ma} < {xb, mb};
      mbig   = swap ? mb : ma;
      msmall = swap ? ma : mb;
      xbig   = swap ? xb : xa;
      xsmall = swap ? xa : xb;
      dexp   = xbig - xsmall;
      dc     = (dexp > 11'd63) ? 6'd63 : dexp[5:0];
      sext   = {msmall, 3'b000};
      sh     = sext >> dc;
      smask  = ~({56{1'b1}} << dc);
      lost   = |(sext & smask);
   end

   // partial product of the multiply
   logic [26:0] pa, pb;
   logic [53:0] pp;
   logic [105:0] pp_sh;

   always_comb begin
      pa = cnt_ff[1] ? {1'b0, ma_ff[52:27]} : ma_ff[26:0];
      pb = cnt_ff[0] ? {1'b0, mb_ff[52:27]} : mb_ff[26:0];
      pp = pa * pb;
      case (cnt_ff)
         2'd0:    pp_sh = {52'd0, pp};
         2'd3:    pp_sh = {pp[51:0], 54'd0};
         default: pp_sh = {25'd0, pp, 27'd0};
      endcase
   end

   // leading one search
   logic [6:0] lpos;
   always_comb begin
      lpos = 7'd0;
      for (int i = 0; i < 106; i++) begin
         if (w_ff[i]) lpos = 7'(i);
      end
   end

   // subnormal right shift
   logic signed [13:0] rs_full;
   logic [6:0]   rs;
   logic [105:0] n2, nmask;
   logic         nlost;

   always_comb begin
      rs_full = 14'sd1 - e_ff;
      rs      = (e_ff > 14'sd0) ? 7'd0 :
                ((rs_full > 14'sd127) ? 7'd127 : rs_full[6:0]);
      n2      = n_ff >> rs;
      nmask   = ~({106{1'b1}} << rs);
      nlost   = |(n_ff & nmask);
   end

   logic [56:0] rsum;
   logic [62:0] packed_r;
   logic        rnd;

   always_comb begin
      rsum = effsub_ff ? ({1'b0, big_ff} - {1'b0, small_ff})
                       : ({1'b0, big_ff} + {1'b0, small_ff});
      rnd = g_ff & (s_ff | sig_ff[0]);
      packed_r = {ef_ff, sig_ff[51:0]} + {62'd0, rnd};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (start) state_in = F_PREP;
         F_PREP:  state_in = special ? F_IDLE : (sub_ff ? F_ADD : F_MUL);
         F_MUL:   if (cnt_ff == 2'd3) state_in = F_LZC;
         F_ADD:   state_in = F_LZC;
         F_LZC:   state_in = F_SHL;
         F_SHL:   state_in = F_SHR;
         F_SHR:   state_in = F_RND;
         F_RND:   state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         done_ff  <= 1'b0;
         if (state_ff == F_PREP && special) done_ff <= 1'b1;
         if (state_ff == F_RND) done_ff <= 1'b1;
         if (state_ff == F_MUL) cnt_ff <= cnt_ff + 2'd1;
         else cnt_ff <= 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            a_ff   <= op_a;
            b_ff   <= op_b;
            sub_ff <= is_sub;
         end
         F_PREP: begin
            result_ff <= spec_val;
            ma_ff     <= ma;
            mb_ff     <= mb;
            big_ff    <= {mbig, 3'b000};
            small_ff  <= sh | {55'd0, lost};
            effsub_ff <= sa ^ sbx;
            zsign_ff  <= sa & sbx;
            zero_ff   <= 1'b0;
            w_ff      <= 106'd0;
            if (sub_ff) begin
               sign_ff  <= swap ? sbx : sa;
               ebase_ff <= 14'(signed'({3'b000, xbig})) - 14'sd55;
            end else begin
               sign_ff  <= sa ^ sb;
               ebase_ff <= 14'(signed'({3'b000, xa})) + 14'(signed'({3'b000, xb}))
                           - 14'sd1127;
            end
         end
         F_MUL: w_ff <= w_ff + pp_sh;
         F_ADD: begin
            w_ff <= {49'd0, rsum};
            if (rsum == 57'd0) begin
               zero_ff <= 1'b1;
               sign_ff <= zsign_ff;
            end
         end
         F_LZC: begin
            lz_ff <= 7'd105 - lpos;
            e_ff  <= ebase_ff + 14'(signed'({7'd0, lpos}));
         end
         F_SHL: n_ff <= w_ff << lz_ff;
         F_SHR: begin
            sig_ff <= n2[105:53];
            g_ff   <= n2[52];
            s_ff   <= (|n2[51:0]) | nlost;
            ef_ff  <= (e_ff > 14'sd0) ? e_ff[10:0] : 11'd0;
            ovf_ff <= e_ff >= 14'sd2047;
         end
         F_RND: begin
            if (zero_ff) result_ff <= {sign_ff, 63'd0};
            else if (ovf_ff) result_ff <= {sign_ff, 11'h7FF, 52'd0};
            else result_ff <= {sign_ff, packed_r};
         end
         default: ;
      endcase
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== sv/cmbc_datapath.sv =====
module cmbc_datapath
   import cmbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [7:0]  data_byte,
   input  logic        restart,
   input  logic        csr_valid,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [7:0]  out_byte
);

   logic [63:0] growth_ff, seed_ff;
   logic        decrypt_ff;
   logic [63:0] x_ff, t_ff, p_ff, q_ff;
   logic [7:0]  byte_ff, out_ff;
   logic        valid_ff;

   logic        is_sub, fpu_done, tent_lt;
   logic [63:0] op_a, op_b, fpu_res;

   // tent branch test: xt < 0.5, false for NaN
   always_comb begin
      tent_lt = !((t_ff[62:52] == 11'h7FF) && (t_ff[51:0] != 52'd0)) &&
                (t_ff[63] || (t_ff[62:0] < F64_HALF[62:0]));
   end

   // operand select
   always_comb begin
      is_sub = 1'b0;
      op_a   = growth_ff;
      op_b   = x_ff;
      case (cmd.op)
         OP_UX: begin
            op_a = growth_ff;
            op_b = x_ff;
         end
         OP_1X: begin
            is_sub = 1'b1;
            op_a   = F64_ONE;
            op_b   = x_ff;
         end
         OP_PQ: begin
            op_a = p_ff;
            op_b = q_ff;
         end
         OP_1T: begin
            is_sub = 1'b1;
            op_a   = F64_ONE;
            op_b   = t_ff;
         end
         OP_CT: begin
            op_a = F64_TENT_K;
            op_b = tent_lt ? t_ff : q_ff;
         end
         default: ;
      endcase
   end

   cmbc_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .is_sub (is_sub),
      .op_a   (op_a),
      .op_b   (op_b),
      .done   (fpu_done),
      .result (fpu_res)
   );

   // byte transform from the new map values
   logic [7:0] key, mixed, enc, dec;
   logic [2:0] amt;
   always_comb begin
      key   = x_ff[7:0];
      amt   = t_ff[7:5];
      mixed = byte_ff ^ key;
      enc   = amt[2] ? rot_right(mixed, amt) : rot_left(mixed, amt);
      dec   = (amt[2] ? rot_left(byte_ff, amt) : rot_right(byte_ff, amt)) ^ key;
   end

   // configuration and map state
   always_ff @(posedge clock) begin
      if (reset) begin
         growth_ff  <= GROWTH_RESET;
         seed_ff    <= SEED_RESET;
         decrypt_ff <= 1'b0;
         x_ff       <= SEED_RESET;
         t_ff       <= SEED_RESET;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_GROWTH:  growth_ff  <= csr_data;
               REG_SEED:    seed_ff    <= csr_data;
               REG_DECRYPT: decrypt_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (cmd.take_item && restart) begin
            x_ff <= seed_ff;
            t_ff <= seed_ff;
         end
         if (fpu_done && cmd.op == OP_PQ) x_ff <= fpu_res;
         if (fpu_done && cmd.op == OP_CT) t_ff <= fpu_res;
      end
   end

   // intermediate products and the input byte
   always_ff @(posedge clock) begin
      if (cmd.take_item) byte_ff <= data_byte;
      if (fpu_done && cmd.op == OP_UX) p_ff <= fpu_res;
      if (fpu_done && (cmd.op == OP_1X || cmd.op == OP_1T)) q_ff <= fpu_res;
      if (cmd.load_out) out_ff <= decrypt_ff ? dec : enc;
   end

   // output register: set on load, drop on accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign stat.fpu_done = fpu_done;
   assign stat.tent_lt  = tent_lt;
   assign stat.out_busy = valid_ff && !out_ready;
   assign out_valid     = valid_ff;
   assign out_byte      = out_ff;

endmodule

// ===== sv/cmbc_ctrl.sv =====
module cmbc_ctrl
   import cmbc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b000_0001,
      S_MUL_UX = 7'b000_0010,
      S_SUB_1X = 7'b000_0100,
      S_MUL_PQ = 7'b000_1000,
      S_SUB_1T = 7'b001_0000,
      S_MUL_T  = 7'b010_0000,
      S_EMIT   = 7'b100_0000
   } state_type;

   state_type state_ff, state_in;
   logic      go_ff, go_in;

   always_comb begin
      state_in      = state_ff;
      go_in         = 1'b0;
      in_ready      = (state_ff == S_IDLE);
      cmd.start     = go_ff;
      cmd.op        = OP_UX;
      cmd.take_item = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.take_item = 1'b1;
               state_in      = S_MUL_UX;
               go_in         = 1'b1;
            end
         end
         S_MUL_UX: begin
            cmd.op = OP_UX;
            if (stat.fpu_done) begin
               state_in = S_SUB_1X;
               go_in    = 1'b1;
            end
         end
         S_SUB_1X: begin
            cmd.op = OP_1X;
            if (stat.fpu_done) begin
               state_in = S_MUL_PQ;
               go_in    = 1'b1;
            end
         end
         S_MUL_PQ: begin
            cmd.op = OP_PQ;
            if (stat.fpu_done) begin
               state_in = stat.tent_lt ? S_MUL_T : S_SUB_1T;
               go_in    = 1'b1;
            end
         end
         S_SUB_1T: begin
            cmd.op = OP_1T;
            if (stat.fpu_done) begin
               state_in = S_MUL_T;
               go_in    = 1'b1;
            end
         end
         S_MUL_T: begin
            cmd.op = OP_CT;
            if (stat.fpu_done) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.op = OP_CT;
            if (!stat.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         go_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import cmbc_pkg::*;

   // Shadow of the cipher: both binary64 maps, the registers and the bytes in flight
   class cipher_scoreboard;
      logic [63:0] growth_rate;
      logic [63:0] seed_value;
      logic        decrypt_mode;
      logic [63:0] logistic_value;
      logic [63:0] tent_value;
      logic [7:0]  pending_bytes[$];
      int          errors;

      function new();
         growth_rate    = GROWTH_RESET;
         seed_value     = SEED_RESET;
         decrypt_mode   = 1'b0;
         logistic_value = SEED_RESET;
         tent_value     = SEED_RESET;
         errors         = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [63:0] value);
         case (index)
            REG_GROWTH:  growth_rate  = value;
            REG_SEED:    seed_value   = value;
            REG_DECRYPT: decrypt_mode = value[0];
            default: ;
         endcase
      endfunction

      function logic [7:0] rotl(logic [7:0] v, int d);
         logic [15:0] w;
         w = {v, v} << d;
         return w[15:8];
      endfunction

      function logic [7:0] rotr(logic [7:0] v, int d);
         logic [15:0] w;
         w = {v, v} >> d;
         return w[7:0];
      endfunction

      // Advance both maps and work out the cipher byte
      function void note_request(logic [7:0] data_byte, logic restart);
         real         u, x, p, q, xt, t;
         logic [7:0]  key, b;
         int          amount;
         if (restart) begin
            logistic_value = seed_value;
            tent_value     = seed_value;
         end
         u = $bitstoreal(growth_rate);
         x = $bitstoreal(logistic_value);
         p = u * x;
         q = 1.0 - x;
         x = p * q;
         logistic_value = $realtobits(x);
         xt = $bitstoreal(tent_value);
         if (xt < 0.5) begin
            xt = $bitstoreal(F64_TENT_K) * xt;
         end else begin
            t  = 1.0 - xt;
            xt = $bitstoreal(F64_TENT_K) * t;
         end
         tent_value = $realtobits(xt);
         key    = logistic_value[7:0];
         amount = tent_value[7:5];
         b      = data_byte;
         if (decrypt_mode) begin
            b = (amount < 4) ? rotr(b, amount) : rotl(b, amount);
            b = b ^ key;
         end else begin
            b = b ^ key;
            b = (amount < 4) ? rotl(b, amount) : rotr(b, amount);
         end
         pending_bytes.push_back(b);
      endfunction

      function void check_response(logic [7:0] out_byte);
         logic [7:0] want;
         if (pending_bytes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: response %02h with no request outstanding", out_byte);
            return;
         end
         want = pending_bytes.pop_front();
         if (out_byte !== want) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: out_byte expected %02h got %02h", want, out_byte);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] out_byte
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   cipher_scoreboard sb;
   int  cycle_count;
   int  rsp_stall;
   bit  req_burst;
   bit  rsp_burst;

   localparam int CYCLE_LIMIT = 600000;

   chaotic_map_byte_cipher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Note accepted beats and register writes in acceptance order
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_request(req_tdata, req_tuser);
      end
   end

   // Check response beats and draw the stall before the next one
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_stall  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         int n;
         sb.check_response(rsp_tdata);
         n = rsp_burst ? 0 : $urandom_range(0, 17);
         if (n == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rsp_stall  <= n;
         end
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         if (rsp_stall == 1)
            rsp_tready <= 1'b1;
      end
   end

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** chaotic_map_byte_cipher: FAILED **");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] data_byte, logic restart);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tuser  <= restart;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain outstanding bytes, then let the datapath settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_bytes(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            req_burst = ~req_burst;
            rsp_burst = $urandom_range(0, 1);
         end
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end
   endtask

   logic [63:0] growth_list[8];
   logic [63:0] seed_list[8];

   initial begin
      sb          = new();
      cycle_count = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tuser   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = REG_GROWTH;
      csr_data    = 64'h0;
      req_burst   = 1'b0;
      rsp_burst   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: byte extremes, restart, both modes, maps from reset
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      wait_idle();
      write_csr(REG_DECRYPT, 64'h1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h3C, 1'b0);
      wait_idle();
      // Seed change without restart keeps the maps running
      write_csr(REG_SEED, 64'h3FE0_0000_0000_0000);
      write_csr(REG_DECRYPT, 64'h0);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b1);
      send_byte(8'h44, 1'b0);
      wait_idle();
      // Infinite growth rate, then a quiet NaN seed
      write_csr(REG_GROWTH, 64'h7FF0_0000_0000_0000);
      send_byte(8'hC3, 1'b1);
      send_byte(8'h3C, 1'b0);
      send_byte(8'hF0, 1'b0);
      wait_idle();
      write_csr(REG_GROWTH, GROWTH_RESET);
      write_csr(REG_SEED, 64'h7FF8_0000_0000_0000);
      send_byte(8'h0F, 1'b1);
      send_byte(8'hE1, 1'b0);
      send_byte(8'h96, 1'b0);
      wait_idle();

      // Random phases over a spread of rates, seeds and modes
      growth_list = '{GROWTH_RESET, 64'h4010_0000_0000_0000, 64'h0,
                      64'hFFFF_FFFF_FFFF_FFFF, 64'h400C_8F5C_28F5_C28F,
                      64'h4010_0000_0000_0000, GROWTH_RESET, 64'h400E_0000_0000_0000};
      seed_list   = '{SEED_RESET, 64'h0, 64'h3FEF_FFFF_FFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFF, 64'h3FE0_0000_0000_0000,
                      64'h0000_0000_0000_0001, 64'h3FD0_0000_0000_0000,
                      64'h3FE0_0000_0000_0000};
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(REG_GROWTH, growth_list[ph]);
         if (ph == 4 || ph == 6)
            write_csr(REG_SEED, {12'h3FE, 20'($urandom), 32'($urandom)});
         else
            write_csr(REG_SEED, seed_list[ph]);
         write_csr(REG_DECRYPT, 64'(ph % 2));
         send_byte(8'($urandom_range(0, 255)), 1'b1);
         random_bytes(ph == 3 ? 40 : 80);
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
         $display("** chaotic_map_byte_cipher: PASSED **");
      end else begin
         $display("** chaotic_map_byte_cipher: FAILED **");
      end
      $finish;
   end

endmodule
